FILE: rtl/rnd_pkg.sv
// Shared types and constants for the reciprocal Newton divider.
// Used by rnd_ctrl, rnd_datapath and reciprocal_newton_divider_core.
package rnd_pkg;

  localparam int DATA_WIDTH          = 32;
  localparam int DIVISOR_WIDTH       = DATA_WIDTH - 1;
  localparam int FRAC_BITS           = 30;
  localparam int DEF_SEED_INDEX_BITS = 8;
  localparam int DEF_REFINE_STEPS    = 2;
  localparam int NORM_STEPS          = 5;
  localparam int MUL_W               = 34;
  localparam int PROD_W              = 2 * MUL_W;
  localparam int Q_W                 = 34;
  localparam int R_W                 = 36;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NORM,
    OP_MUL_BY,
    OP_SUB_T,
    OP_MUL_Y,
    OP_UPD_Y,
    OP_SEED,
    OP_MUL_Q,
    OP_ROUND,
    OP_MUL_R,
    OP_REM,
    OP_FIX,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] norm_step;
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic fix_done;
  } dp_status_t;

endpackage

FILE: rtl/reciprocal_newton_divider_core.sv
// Top level of the reciprocal Newton divider: controller plus datapath.
// Depends on rnd_pkg, rnd_ctrl and rnd_datapath.
//
// Computes floor(dividend / divisor) for a signed 32-bit dividend and a
// non-negative 31-bit divisor; a zero divisor returns 0. One item is worked
// on at a time, and all multiplies share a single registered 34x34 multiplier.
// An item goes through normalization, a seed lookup, the refinement steps
// (two multiplies each, two steps by default), the final multiply, rounding
// and remainder, a check of the remainder with a correction step wherever it
// is still out of range, and output and return to idle; a zero divisor goes
// from normalization straight to output. The output register lets the next
// item be accepted while a result still waits to be taken.
module reciprocal_newton_divider_core import rnd_pkg::*; #(
  parameter int SEED_INDEX_BITS = DEF_SEED_INDEX_BITS,
  parameter int REFINE_STEPS    = DEF_REFINE_STEPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [DATA_WIDTH-1:0]    dividend,
  input  logic        [DIVISOR_WIDTH-1:0] divisor,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [DATA_WIDTH-1:0]    quotient
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rnd_ctrl #(
    .REFINE_STEPS(REFINE_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rnd_datapath #(
    .SEED_INDEX_BITS(SEED_INDEX_BITS)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .dividend(dividend),
    .divisor (divisor),
    .status  (status),
    .quotient(quotient)
  );

endmodule

FILE: rtl/rnd_datapath.sv
// Datapath of the divider: normalizer, seed table, shared multiplier and
// remainder correction. Depends on rnd_pkg; driven by rnd_ctrl commands.
module rnd_datapath import rnd_pkg::*; #(
  parameter int SEED_INDEX_BITS = DEF_SEED_INDEX_BITS
) (
  input  logic                            clk,
  input  dp_cmd_t                         cmd,
  input  logic signed [DATA_WIDTH-1:0]    dividend,
  input  logic        [DIVISOR_WIDTH-1:0] divisor,
  output dp_status_t                      status,
  output logic signed [DATA_WIDTH-1:0]    quotient
);

  localparam int SEED_ENTRIES = 1 << SEED_INDEX_BITS;

  logic signed [DATA_WIDTH-1:0]    a;
  logic        [DIVISOR_WIDTH-1:0] b;
  logic        [DIVISOR_WIDTH-1:0] nb;
  logic        [4:0]               lz;
  logic        [31:0]              y;
  logic        [31:0]              t;
  logic signed [PROD_W-1:0]        p;
  logic signed [Q_W-1:0]           q;
  logic signed [R_W-1:0]           r;

  logic        [31:0]              seed_rom [SEED_ENTRIES];
  logic        [4:0]               shift_w;
  logic                            top_zero;
  logic        [29:0]              bn;
  logic        [4:0]               s;
  logic signed [MUL_W-1:0]         ma;
  logic signed [MUL_W-1:0]         mb;
  logic        [37:0]              by;
  logic signed [PROD_W-1:0]        rnd_sum;
  logic signed [R_W-1:0]           b_ext;

  // Seed entry idx holds 1/(0.5 + idx/2^(K+1)) in Q2.30, folded at elaboration.
  for (genvar g = 0; g < SEED_ENTRIES; g++) begin : g_seed
    localparam logic [63:0] SEED_Q = (64'd1 << (FRAC_BITS + 1 + SEED_INDEX_BITS))
                                     / (64'(SEED_ENTRIES) + 64'(g));
    assign seed_rom[g] = SEED_Q[31:0];
  end

  assign shift_w  = 5'd16 >> cmd.norm_step;
  assign top_zero = (nb >> (5'd31 - shift_w)) == '0;
  assign bn       = nb[30:1];
  assign s        = 5'd31 - lz;
  assign by       = p[67:30];
  assign b_ext    = $signed({5'b0, b});
  assign rnd_sum  = p + (68'sd1 <<< (7'd29 + 7'(s)));

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_MUL_BY: begin
        ma = $signed({4'b0, bn});
        mb = $signed({2'b0, y});
      end
      OP_MUL_Y: begin
        ma = $signed({2'b0, y});
        mb = $signed({2'b0, t});
      end
      OP_MUL_Q: begin
        ma = $signed({{2{a[31]}}, a});
        mb = $signed({2'b0, y});
      end
      OP_MUL_R: begin
        ma = q;
        mb = $signed({3'b0, b});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
    unique case (cmd.op)
      OP_LOAD: begin
        a  <= dividend;
        b  <= divisor;
        nb <= divisor;
        lz <= '0;
        q  <= '0;
      end
      OP_NORM: begin
        if (top_zero) begin
          nb <= nb << shift_w;
          lz <= lz + shift_w;
        end
      end
      OP_SEED: y <= seed_rom[bn[28 -: SEED_INDEX_BITS]];
      OP_SUB_T: t <= (by > 38'h80000000) ? 32'd0 : 32'(38'h80000000 - by);
      OP_UPD_Y: y <= (by > 38'h80000000) ? 32'h80000000 : by[31:0];
      // Round half up, then floor by an arithmetic shift.
      OP_ROUND: q <= Q_W'(rnd_sum >>> (7'd30 + 7'(s)));
      OP_REM: r <= $signed({{4{a[31]}}, a}) - p[R_W-1:0];
      OP_FIX: begin
        if (!r[R_W-1]) begin
          q <= q + Q_W'(1);
          r <= r - b_ext;
        end else begin
          q <= q - Q_W'(1);
          r <= r + b_ext;
        end
      end
      OP_OUT: quotient <= q[DATA_WIDTH-1:0];
      default: begin
      end
    endcase
  end

  assign status.b_zero   = (b == '0);
  assign status.fix_done = !r[R_W-1] && (r < b_ext);

endmodule

FILE: rtl/rnd_ctrl.sv
// Sequencer for the divider: walks normalization, refinement, final
// multiply and correction, and owns both handshakes. Depends on rnd_pkg.
module rnd_ctrl import rnd_pkg::*; #(
  parameter int REFINE_STEPS = DEF_REFINE_STEPS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int RW = (REFINE_STEPS > 1) ? $clog2(REFINE_STEPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SEED, S_MBY, S_SUBT, S_MY, S_UPDY,
    S_MQ, S_RND, S_MR, S_REM, S_FIX, S_OUT
  } state_t;

  state_t     state;
  logic [2:0] norm_cnt;
  logic [RW-1:0] ref_cnt;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.norm_step = norm_cnt;
    unique case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_NORM:  cmd.op = OP_NORM;
      S_SEED:  cmd.op = OP_SEED;
      S_MBY:   cmd.op = OP_MUL_BY;
      S_SUBT:  cmd.op = OP_SUB_T;
      S_MY:    cmd.op = OP_MUL_Y;
      S_UPDY:  cmd.op = OP_UPD_Y;
      S_MQ:    cmd.op = OP_MUL_Q;
      S_RND:   cmd.op = OP_ROUND;
      S_MR:    cmd.op = OP_MUL_R;
      S_REM:   cmd.op = OP_REM;
      S_FIX:   cmd.op = status.fix_done ? OP_NONE : OP_FIX;
      S_OUT:   cmd.op = out_free ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      norm_cnt  <= '0;
      ref_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(state == S_OUT && out_free)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          norm_cnt <= '0;
          ref_cnt  <= '0;
          if (in_valid) state <= S_NORM;
        end
        S_NORM: begin
          // A zero divisor leaves the loaded zero quotient untouched.
          if (norm_cnt == 3'd0 && status.b_zero) begin
            state <= S_OUT;
          end else if (norm_cnt == 3'(NORM_STEPS - 1)) begin
            state <= S_SEED;
          end else begin
            norm_cnt <= norm_cnt + 3'd1;
          end
        end
        S_SEED: state <= S_MBY;
        S_MBY:  state <= S_SUBT;
        S_SUBT: state <= S_MY;
        S_MY:   state <= S_UPDY;
        S_UPDY: begin
          if (ref_cnt == RW'(REFINE_STEPS - 1)) begin
            state <= S_MQ;
          end else begin
            ref_cnt <= ref_cnt + RW'(1);
            state   <= S_MBY;
          end
        end
        S_MQ:  state <= S_RND;
        S_RND: state <= S_MR;
        S_MR:  state <= S_REM;
        S_REM: state <= S_FIX;
        S_FIX: if (status.fix_done) state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_NORM))
    else $error("accepted transfer did not start normalization");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the output state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_fix_settles: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX && status.fix_done) |=> (state == S_OUT))
    else $error("correction finished but no result issued");

endmodule

FILE: tb/reciprocal_newton_divider_core_checker.sv
// Checker for the reciprocal Newton divider: watches both channels, predicts
// the floored quotient of each accepted transfer and compares results in order.
// Depends on rnd_pkg for the field widths.
module reciprocal_newton_divider_core_checker import rnd_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic signed [DATA_WIDTH-1:0]    dividend,
  input  logic        [DIVISOR_WIDTH-1:0] divisor,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [DATA_WIDTH-1:0]    quotient,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [DATA_WIDTH-1:0] quotients_due[$];

  // Exact floor division; the Newton estimate is corrected to this anyway.
  function automatic logic signed [DATA_WIDTH-1:0] floor_quotient(
      logic signed [DATA_WIDTH-1:0] num, logic [DIVISOR_WIDTH-1:0] den);
    longint n;
    longint d;
    longint q;
    n = num;
    d = den;
    if (d == 0) return '0;
    q = n / d;
    if ((n % d != 0) && (n < 0)) q = q - 1;
    return q[DATA_WIDTH-1:0];
  endfunction

  assign pending = quotients_due.size();

  always @(posedge clk) begin
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_valid && !in_stall)
        quotients_due.push_back(floor_quotient(dividend, divisor));
      if (out_valid && !out_stall) begin
        if (quotients_due.size() == 0) begin
          $display("%0t: unexpected quotient %0d", $realtime, quotient);
          errors <= errors + 1;
        end else begin
          if (quotient !== quotients_due[0]) begin
            $display("%0t: quotient expected %0d actual %0d", $realtime,
                     quotients_due[0], quotient);
            errors <= errors + 1;
          end
          void'(quotients_due.pop_front());
        end
      end
    end
  end
endmodule

FILE: tb/reciprocal_newton_divider_core_test.sv
// Top of the divider testbench: clock, reset, directed and random dividend
// and divisor transfers, random result stalls and the verdict.
// Depends on rnd_pkg, reciprocal_newton_divider_core and its checker.
module reciprocal_newton_divider_core_test;
  import rnd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [DATA_WIDTH-1:0] dividend = '0;
  logic [DIVISOR_WIDTH-1:0] divisor = '0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [DATA_WIDTH-1:0] quotient;
  int errors;
  int pending;
  bit sending_done = 0;
  bit long_hold = 0;

  always #2 clk = ~clk;

  reciprocal_newton_divider_core u_dut (.*);
  reciprocal_newton_divider_core_checker u_checker (.*);

  function automatic logic [DIVISOR_WIDTH-1:0] random_divisor();
    int bits;
    logic [DIVISOR_WIDTH-1:0] d;
    bits = $urandom_range(DIVISOR_WIDTH, 1);
    d = DIVISOR_WIDTH'({$urandom, $urandom});
    d = d >> (DIVISOR_WIDTH - bits);
    if ($urandom_range(15, 0) == 0) d = '0;
    return d;
  endfunction

  // The stall seen at a falling edge holds until the next rising edge.
  task automatic send_one(logic signed [DATA_WIDTH-1:0] num,
                          logic [DIVISOR_WIDTH-1:0] den, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    dividend <= num;
    divisor <= den;
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic signed [DATA_WIDTH-1:0] nums[10];
    logic [DIVISOR_WIDTH-1:0] dens[6];
    nums = '{32'sh80000000, 32'sh7fffffff, 0, 1, -1, 7, -7, 32'sh55555555,
             32'shaaaaaaaa, -100};
    dens = '{0, 1, 2, 3, 31'h7fffffff, 31'h40000000};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (nums[i]) send_one(nums[i], dens[i % 6], 0);
    send_one(32'sh80000000, 1, 0);
    send_one(-1, 31'h7fffffff, 0);
    send_one(32'sh7fffffff, 31'h7fffffff, 0);
    send_one(100, 7, 0);
    send_one(-100, 31'h55555555, 0);
    long_hold <= 1;
    for (int i = 0; i < 12; i++) send_one($urandom, random_divisor(), 0);
    for (int i = 0; i < 440; i++) begin
      logic signed [DATA_WIDTH-1:0] num;
      num = $urandom;
      if ($urandom_range(7, 0) == 0) num = num >>> $urandom_range(31, 0);
      send_one(num, random_divisor(),
               ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(18, 0));
    end
    in_valid <= 0;
    sending_done <= 1;
  end

  // Result side: random stalls, plus one long hold-off to back up the block.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        long_hold <= 0;
      end
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(18, 0);
      out_stall <= (gap != 0);
      repeat (gap) @(negedge clk);
      out_stall <= 0;
      while (!out_valid) @(negedge clk);
      @(negedge clk);
    end
  end

  initial begin
    @(posedge sending_done);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("reciprocal_newton_divider_core_test: done, clean");
    else $display("reciprocal_newton_divider_core_test: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("reciprocal_newton_divider_core_test: done, errors");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/rnd_pkg.sv
rtl/rnd_datapath.sv
rtl/rnd_ctrl.sv
rtl/reciprocal_newton_divider_core.sv
tb/reciprocal_newton_divider_core_checker.sv
tb/reciprocal_newton_divider_core_test.sv
